// File: rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// shared widths, codes and types of the trapezoid speed profile block
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int SPEED_W    = 14;
    localparam int CORR_W     = 10;
    localparam int ANGLE_W    = 24;
    localparam int PID_W      = 21;
    localparam int TARGET_W   = 13;
    localparam int STEP_W     = 8;
    localparam int GAIN_W     = 4;
    localparam int BRAKE_W    = 12;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // move phases
    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_END      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ANGLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_APPROACH_SPEED = 3'd7;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd5;
    localparam logic [BRAKE_W-1:0] BRAKE_RESET = 12'd700;
    localparam int                 CORR_LIMIT  = 500;

    typedef struct packed {
        logic signed [TARGET_W-1:0] target_speed;
        logic [STEP_W-1:0]          accel_step;
        logic [STEP_W-1:0]          decel_step;
        logic signed [ANGLE_W-1:0]  accel_end_angle;
        logic signed [ANGLE_W-1:0]  decel_start_angle;
        logic signed [ANGLE_W-1:0]  stop_angle;
        logic [GAIN_W-1:0]          correction_gain;
        logic [BRAKE_W-1:0]         approach_speed;
    } cfg_t;

    typedef struct packed {
        logic                      emit;
        logic                      stop;
        logic signed [SPEED_W-1:0] x_speed;
        logic signed [CORR_W-1:0]  corr;
        logic [1:0]                phase;
        logic signed [SPEED_W-1:0] ramp_next;
        logic [1:0]                phase_next;
    } upd_t;

endpackage

// File: rtl/tsp_cfg_regs.sv
// ----------------------------------------------------------------------------
// tsp_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module tsp_cfg_regs
    import tsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_speed      <= '0;
            cfg_reg.accel_step        <= '0;
            cfg_reg.decel_step        <= '0;
            cfg_reg.accel_end_angle   <= '0;
            cfg_reg.decel_start_angle <= '0;
            cfg_reg.stop_angle        <= '0;
            cfg_reg.correction_gain   <= GAIN_RESET;
            cfg_reg.approach_speed    <= BRAKE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_SPEED:   cfg_reg.target_speed      <= $signed(cfg_wdata[TARGET_W-1:0]);
                REG_ACCEL_STEP:     cfg_reg.accel_step        <= cfg_wdata[STEP_W-1:0];
                REG_DECEL_STEP:     cfg_reg.decel_step        <= cfg_wdata[STEP_W-1:0];
                REG_ACCEL_END:      cfg_reg.accel_end_angle   <= $signed(cfg_wdata[ANGLE_W-1:0]);
                REG_DECEL_START:    cfg_reg.decel_start_angle <= $signed(cfg_wdata[ANGLE_W-1:0]);
                REG_STOP_ANGLE:     cfg_reg.stop_angle        <= $signed(cfg_wdata[ANGLE_W-1:0]);
                REG_GAIN:           cfg_reg.correction_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_APPROACH_SPEED: cfg_reg.approach_speed    <= cfg_wdata[BRAKE_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tsp_update.sv
// ----------------------------------------------------------------------------
// tsp_update
// single-pass update: ramp step, heading correction and phase advance
// ----------------------------------------------------------------------------
module tsp_update
    import tsp_pkg::*;
(
    input  cfg_t                      cfg,
    input  logic                      op,
    input  logic signed [ANGLE_W-1:0] rotated_angle,
    input  logic signed [PID_W-1:0]   pid_value,
    input  logic signed [SPEED_W-1:0] ramp_speed,
    input  logic [1:0]                move_phase,
    output upd_t                      upd
);

    localparam int WIDE_W = SPEED_W + 1;
    localparam int PROD_W = PID_W + GAIN_W + 1;

    logic signed [WIDE_W-1:0] ramp_w;
    logic signed [WIDE_W-1:0] target_w;
    logic signed [WIDE_W-1:0] brake_w;
    logic signed [WIDE_W-1:0] acc_w;
    logic signed [WIDE_W-1:0] dec_w;
    logic signed [WIDE_W-1:0] ramp_new;
    logic                     tgt_pos;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] quot;
    logic signed [CORR_W-1:0] corr;
    logic                     tick;

    assign ramp_w   = WIDE_W'(ramp_speed);
    assign target_w = WIDE_W'(cfg.target_speed);
    assign brake_w  = $signed({{(WIDE_W-BRAKE_W){1'b0}}, cfg.approach_speed});
    assign acc_w    = $signed({{(WIDE_W-STEP_W){1'b0}}, cfg.accel_step});
    assign dec_w    = $signed({{(WIDE_W-STEP_W){1'b0}}, cfg.decel_step});
    assign tgt_pos  = !cfg.target_speed[TARGET_W-1];

    always_comb begin
        ramp_new = ramp_w;
        unique case (move_phase)
            PH_ACCEL: begin
                if (tgt_pos) begin
                    ramp_new = (ramp_w < target_w) ? ramp_w + acc_w : target_w;
                end else begin
                    ramp_new = (ramp_w > target_w) ? ramp_w - acc_w : target_w;
                end
            end
            PH_DECEL: begin
                if (tgt_pos) begin
                    ramp_new = (ramp_w > brake_w) ? ramp_w - dec_w : brake_w;
                end else begin
                    ramp_new = (ramp_w < -brake_w) ? ramp_w + dec_w : -brake_w;
                end
            end
            default: ramp_new = ramp_w;
        endcase
    end

    // gain times pid, divided by 16 rounding toward zero, then clamped
    assign prod   = $signed({1'b0, cfg.correction_gain}) * pid_value;
    assign biased = prod[PROD_W-1] ? prod + PROD_W'(15) : prod;
    assign quot   = biased >>> 4;

    always_comb begin
        if (quot > PROD_W'(CORR_LIMIT)) begin
            corr = CORR_W'(CORR_LIMIT);
        end else if (quot < -PROD_W'(CORR_LIMIT)) begin
            corr = -CORR_W'(CORR_LIMIT);
        end else begin
            corr = quot[CORR_W-1:0];
        end
    end

    assign tick = (op == OP_TICK) && (move_phase != PH_DONE);

    always_comb begin
        upd.emit       = tick;
        upd.stop       = 1'b0;
        upd.x_speed    = ramp_new[SPEED_W-1:0];
        upd.corr       = corr;
        upd.phase      = move_phase;
        upd.ramp_next  = ramp_speed;
        upd.phase_next = move_phase;
        if (op == OP_START) begin
            upd.ramp_next  = '0;
            upd.phase_next = PH_ACCEL;
        end else if (tick) begin
            upd.ramp_next = ramp_new[SPEED_W-1:0];
            unique case (move_phase)
                PH_ACCEL: begin
                    if (rotated_angle >= cfg.accel_end_angle) upd.phase_next = PH_CRUISE;
                end
                PH_CRUISE: begin
                    if (rotated_angle >= cfg.decel_start_angle) upd.phase_next = PH_DECEL;
                end
                default: begin
                    if (rotated_angle >= cfg.stop_angle) begin
                        upd.phase_next = PH_DONE;
                        upd.stop       = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/trapezoid_speed_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_speed_profile
// trapezoidal speed profile with clamped heading correction for a straight move
// ----------------------------------------------------------------------------
// a result transaction passes the input register and then the output register
// throughput: one input transaction per cycle while the result side keeps ready high;
// the stop tick yields two results and holds the input off while the zero command
// is owed, the zero command being offered as soon as the first result is taken
// reset (aresetn low, synchronous): channels empty, speed 0, phase done, registers
// at their defaults (gain 5, approach speed 700, all others 0)
module trapezoid_speed_profile
    import tsp_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,

    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,

    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic signed [ANGLE_W-1:0]    s_rotated_angle,
    input  logic signed [PID_W-1:0]      s_pid_value,

    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SPEED_W-1:0]    m_x_speed,
    output logic signed [CORR_W-1:0]     m_heading_correction,
    output logic [1:0]                   m_phase,
    output logic                         m_last
);

    cfg_t cfg;
    upd_t upd;

    // input register
    logic                      in_valid_reg;
    logic                      in_op_reg;
    logic signed [ANGLE_W-1:0] in_angle_reg;
    logic signed [PID_W-1:0]   in_pid_reg;

    // move state
    logic signed [SPEED_W-1:0] ramp_reg;
    logic [1:0]                phase_reg;

    // output register, plus a flag for the trailing zero command
    logic                      m_valid_reg;
    logic                      pend_reg;
    logic signed [SPEED_W-1:0] m_x_speed_reg;
    logic signed [CORR_W-1:0]  m_corr_reg;
    logic [1:0]                m_phase_reg;
    logic                      m_last_reg;

    logic out_free;
    logic consume;

    tsp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tsp_update u_update (
        .cfg           (cfg),
        .op            (in_op_reg),
        .rotated_angle (in_angle_reg),
        .pid_value     (in_pid_reg),
        .ramp_speed    (ramp_reg),
        .move_phase    (phase_reg),
        .upd           (upd)
    );

    // the output register can take a new result when empty, or when its
    // current transaction completes and no zero command is owed
    assign out_free = !m_valid_reg || (m_ready && !pend_reg);
    assign consume  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || consume;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_op;
            in_angle_reg <= s_rotated_angle;
            in_pid_reg   <= s_pid_value;
        end
    end

    // move state follows every consumed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_reg  <= '0;
            phase_reg <= PH_DONE;
        end else if (consume) begin
            ramp_reg  <= upd.ramp_next;
            phase_reg <= upd.phase_next;
        end
    end

    // output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            priority if (consume && upd.emit) begin
                m_valid_reg <= 1'b1;
                pend_reg    <= upd.stop;
            end else if (m_valid_reg && m_ready) begin
                // a pending zero command replaces the decelerate command
                m_valid_reg <= pend_reg;
                pend_reg    <= 1'b0;
            end else begin
                m_valid_reg <= m_valid_reg;
                pend_reg    <= pend_reg;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        priority if (consume && upd.emit) begin
            m_x_speed_reg <= upd.x_speed;
            m_corr_reg    <= upd.corr;
            m_phase_reg   <= upd.phase;
            m_last_reg    <= !upd.stop;
        end else if (m_valid_reg && m_ready && pend_reg) begin
            m_x_speed_reg <= '0;
            m_corr_reg    <= '0;
            m_phase_reg   <= PH_DONE;
            m_last_reg    <= 1'b1;
        end else begin
            m_x_speed_reg <= m_x_speed_reg;
            m_corr_reg    <= m_corr_reg;
            m_phase_reg   <= m_phase_reg;
            m_last_reg    <= m_last_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_x_speed            = m_x_speed_reg;
    assign m_heading_correction = m_corr_reg;
    assign m_phase              = m_phase_reg;
    assign m_last               = m_last_reg;

    // a pending zero command always sits behind a shown decelerate command
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (m_valid_reg && m_phase_reg == PH_DECEL && !m_last_reg))
        else $error("zero command pending without a decelerate result");

    // a result that is not last always has its zero command owed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> pend_reg)
        else $error("non-last result without a following zero command");

    // the stop tick leaves the move done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && upd.stop) |=> (phase_reg == PH_DONE && pend_reg))
        else $error("stop tick did not end the move");

    // nothing is consumed while a zero command still waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !consume)
        else $error("item consumed while a zero command is owed");

endmodule

// File: verif/tsp_command_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsp_command_checker
// watches both channels and the register port, predicts each speed command
// and compares every result transaction field by field with the oldest one
// ----------------------------------------------------------------------------
module tsp_command_checker
    import tsp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_op,
    input  logic signed [ANGLE_W-1:0] s_rotated_angle,
    input  logic signed [PID_W-1:0]   s_pid_value,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [SPEED_W-1:0] m_x_speed,
    input  logic signed [CORR_W-1:0]  m_heading_correction,
    input  logic [1:0]                m_phase,
    input  logic                      m_last,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic signed [SPEED_W-1:0] x_speed;
        logic signed [CORR_W-1:0]  corr;
        logic [1:0]                phase;
        logic                      last;
    } command_t;

    command_t                  cmd_expected[$];
    cfg_t                      profile;
    logic signed [SPEED_W-1:0] ramp_speed;
    logic [1:0]                move_phase;

    function automatic void push_command(int speed, int corr, logic [1:0] ph, logic lst);
        command_t cmd;
        cmd.x_speed = speed[SPEED_W-1:0];
        cmd.corr    = corr[CORR_W-1:0];
        cmd.phase   = ph;
        cmd.last    = lst;
        cmd_expected.push_back(cmd);
    endfunction

    // one profile update per tick: speed first, then the angle threshold
    function automatic void predict_command(logic op, logic signed [ANGLE_W-1:0] angle,
                                            logic signed [PID_W-1:0] pid);
        int         speed, target, brake, astep, dstep, corr, ang;
        logic [1:0] ph;
        speed  = ramp_speed;
        target = profile.target_speed;
        brake  = int'(profile.approach_speed);
        astep  = int'(profile.accel_step);
        dstep  = int'(profile.decel_step);
        ang    = angle;
        ph     = move_phase;
        if (op == OP_START) begin
            ramp_speed = '0;
            move_phase = PH_ACCEL;
            return;
        end
        if (ph == PH_DONE)
            return;

        if (ph == PH_ACCEL) begin
            if (target >= 0)
                speed = (speed < target) ? speed + astep : target;
            else
                speed = (speed > target) ? speed - astep : target;
        end else if (ph == PH_DECEL) begin
            if (target >= 0)
                speed = (speed > brake) ? speed - dstep : brake;
            else
                speed = (speed < -brake) ? speed + dstep : -brake;
        end
        ramp_speed = speed[SPEED_W-1:0];

        // division on int truncates toward zero
        corr = (int'(profile.correction_gain) * int'(pid)) / 16;
        if (corr > CORR_LIMIT)
            corr = CORR_LIMIT;
        if (corr < -CORR_LIMIT)
            corr = -CORR_LIMIT;

        case (ph)
            PH_ACCEL: begin
                push_command(speed, corr, PH_ACCEL, 1'b1);
                if (ang >= int'(profile.accel_end_angle))
                    move_phase = PH_CRUISE;
            end
            PH_CRUISE: begin
                push_command(speed, corr, PH_CRUISE, 1'b1);
                if (ang >= int'(profile.decel_start_angle))
                    move_phase = PH_DECEL;
            end
            default: begin
                if (ang >= int'(profile.stop_angle)) begin
                    push_command(speed, corr, PH_DECEL, 1'b0);
                    push_command(0, 0, PH_DONE, 1'b1);
                    move_phase = PH_DONE;
                end else begin
                    push_command(speed, corr, PH_DECEL, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void compare_command(command_t exp_cmd);
        bit bad;
        bad = 1'b0;
        if (m_x_speed !== exp_cmd.x_speed) begin
            $display("%0t: x_speed expected %0d, got %0d", $time, exp_cmd.x_speed, m_x_speed);
            bad = 1'b1;
        end
        if (m_heading_correction !== exp_cmd.corr) begin
            $display("%0t: heading_correction expected %0d, got %0d",
                     $time, exp_cmd.corr, m_heading_correction);
            bad = 1'b1;
        end
        if (m_phase !== exp_cmd.phase) begin
            $display("%0t: phase expected %0d, got %0d", $time, exp_cmd.phase, m_phase);
            bad = 1'b1;
        end
        if (m_last !== exp_cmd.last) begin
            $display("%0t: last expected %0d, got %0d", $time, exp_cmd.last, m_last);
            bad = 1'b1;
        end
        if (bad)
            fail_count++;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            profile                 = '0;
            profile.correction_gain = GAIN_RESET;
            profile.approach_speed  = BRAKE_RESET;
            ramp_speed              = '0;
            move_phase              = PH_DONE;
            cmd_expected.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (cmd_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got x_speed %0d phase %0d",
                             $time, m_x_speed, m_phase);
                    fail_count++;
                end else begin
                    compare_command(cmd_expected.pop_front());
                end
            end
            // a register write lands before any item taken at the same edge is processed
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TARGET_SPEED:   profile.target_speed      = cfg_wdata[TARGET_W-1:0];
                    REG_ACCEL_STEP:     profile.accel_step        = cfg_wdata[STEP_W-1:0];
                    REG_DECEL_STEP:     profile.decel_step        = cfg_wdata[STEP_W-1:0];
                    REG_ACCEL_END:      profile.accel_end_angle   = cfg_wdata[ANGLE_W-1:0];
                    REG_DECEL_START:    profile.decel_start_angle = cfg_wdata[ANGLE_W-1:0];
                    REG_STOP_ANGLE:     profile.stop_angle        = cfg_wdata[ANGLE_W-1:0];
                    REG_GAIN:           profile.correction_gain   = cfg_wdata[GAIN_W-1:0];
                    REG_APPROACH_SPEED: profile.approach_speed    = cfg_wdata[BRAKE_W-1:0];
                    default:            ;
                endcase
            end
            if (s_valid && s_ready)
                predict_command(s_op, s_rotated_angle, s_pid_value);
        end
        pending = cmd_expected.size();
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives whole moves through the trapezoid speed profile: register setup,
// start, ticks with a rising wheel angle, random stalls on both channels;
// the checker beside the block predicts and compares every command
// ----------------------------------------------------------------------------
module testbench;
    import tsp_pkg::*;

    localparam int QUIET_LIMIT   = 2000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 8;     // margin after the last outstanding command
    localparam int HOLD_CYCLES   = 250;   // long result-side back-pressure
    localparam int ITEM_TARGET   = 1000;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_op;
    logic signed [ANGLE_W-1:0] s_rotated_angle;
    logic signed [PID_W-1:0]   s_pid_value;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [SPEED_W-1:0] m_x_speed;
    logic signed [CORR_W-1:0]  m_heading_correction;
    logic [1:0]                m_phase;
    logic                      m_last;

    int   fail_count;
    int   pending;
    int   items_sent;
    int   quiet_cycles;
    bit   tx_idle_on;
    bit   rx_idle_on;
    int   rx_hold_cycles;
    cfg_t profile;

    trapezoid_speed_profile i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_rotated_angle      (s_rotated_angle),
        .s_pid_value          (s_pid_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_x_speed            (m_x_speed),
        .m_heading_correction (m_heading_correction),
        .m_phase              (m_phase),
        .m_last               (m_last)
    );

    tsp_command_checker i_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_rotated_angle      (s_rotated_angle),
        .s_pid_value          (s_pid_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_x_speed            (m_x_speed),
        .m_heading_correction (m_heading_correction),
        .m_phase              (m_phase),
        .m_last               (m_last),
        .fail_count           (fail_count),
        .pending              (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: a run that stops moving transactions is a failure
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog expired, %0d commands still outstanding", $time, pending);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random stall before each transaction, or one long hold-off
    // when the stimulus asks for it (counted here, not by the sender)
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 18) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // one register write per cycle; the caller lowers the enable after a burst
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    // write the whole register set, sign-extending the signed target
    task automatic load_profile(input cfg_t p);
        profile = p;
        put_reg(REG_TARGET_SPEED,
                {{(CFG_DATA_W-TARGET_W){p.target_speed[TARGET_W-1]}}, p.target_speed});
        put_reg(REG_ACCEL_STEP,     CFG_DATA_W'(p.accel_step));
        put_reg(REG_DECEL_STEP,     CFG_DATA_W'(p.decel_step));
        put_reg(REG_ACCEL_END,      p.accel_end_angle);
        put_reg(REG_DECEL_START,    p.decel_start_angle);
        put_reg(REG_STOP_ANGLE,     p.stop_angle);
        put_reg(REG_GAIN,           CFG_DATA_W'(p.correction_gain));
        put_reg(REG_APPROACH_SPEED, CFG_DATA_W'(p.approach_speed));
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // offer one transaction after a random gap, hold it until accepted
    task automatic send_item(input logic op, input logic signed [ANGLE_W-1:0] angle,
                             input logic signed [PID_W-1:0] pid);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_rotated_angle <= angle;
        s_pid_value     <= pid;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
        @(negedge aclk);
    endtask

    // sender pause: wait for every outstanding command, then cover
    // start transactions and ticks while done that are still in flight
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // half of the pid values small so the clamp is not always hit
    function automatic logic signed [PID_W-1:0] random_pid();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(PID_W-1){1'b1}}};
            1:       return {1'b1, {(PID_W-1){1'b0}}};
            2, 3:    return PID_W'($urandom);
            default: return PID_W'(int'($urandom_range(0, 1200)) - 600);
        endcase
    endfunction

    function automatic cfg_t random_profile();
        cfg_t p;
        int   base, a_end, d_start, s_ang;
        case ($urandom_range(0, 7))
            0:       p.target_speed = 13'sd4095;
            1:       p.target_speed = -13'sd4095;
            2:       p.target_speed = '0;
            default: p.target_speed = TARGET_W'(int'($urandom_range(0, 8190)) - 4095);
        endcase
        p.accel_step      = ($urandom_range(0, 7) == 0) ? 8'd255 : STEP_W'($urandom_range(0, 255));
        p.decel_step      = ($urandom_range(0, 7) == 0) ? 8'd0 : STEP_W'($urandom_range(0, 255));
        p.correction_gain = GAIN_W'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       p.approach_speed = 12'd4095;
            1:       p.approach_speed = '0;
            default: p.approach_speed = BRAKE_W'($urandom_range(0, 4095));
        endcase
        // ordered thresholds; now and then moved far from zero
        base    = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16000000)) - 8000000 : 0;
        a_end   = base + int'($urandom_range(0, 1500));
        d_start = a_end + int'($urandom_range(0, 3000));
        s_ang   = d_start + int'($urandom_range(0, 2000));
        p.accel_end_angle   = a_end[ANGLE_W-1:0];
        p.decel_start_angle = d_start[ANGLE_W-1:0];
        p.stop_angle        = s_ang[ANGLE_W-1:0];
        return p;
    endfunction

    // a full move: start, ticks with rising angle past the stop angle, then
    // a few ticks once done; noisy moves mix in wild angles and restarts
    task automatic run_move(input int stride, input bit noisy);
        int ang, stop_at;
        stop_at = profile.stop_angle;
        ang     = int'(profile.accel_end_angle) - int'($urandom_range(0, 600));
        send_item(OP_START, ANGLE_W'($urandom), random_pid());
        while (ang < stop_at) begin
            if (noisy && $urandom_range(0, 39) == 0)
                send_item(OP_START, ANGLE_W'($urandom), random_pid());
            else if (noisy && $urandom_range(0, 15) == 0)
                send_item(OP_TICK, ANGLE_W'($urandom), random_pid());
            else
                send_item(OP_TICK, ang[ANGLE_W-1:0], random_pid());
            ang += int'($urandom_range(1, stride));
        end
        repeat (3 + $urandom_range(0, 1)) begin
            send_item(OP_TICK, ang[ANGLE_W-1:0], random_pid());
            ang += int'($urandom_range(0, 50));
        end
    endtask

    initial begin : stimulus
        cfg_t p;
        int   move_count;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_op            = OP_TICK;
        s_rotated_angle = '0;
        s_pid_value     = '0;
        items_sent      = 0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold_cycles  = 0;
        profile                 = '0;
        profile.correction_gain = GAIN_RESET;
        profile.approach_speed  = BRAKE_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // tick right after reset: block is done, nothing comes back
        send_item(OP_TICK, 24'sh7FFFFF, 21'sh0FFFFF);
        settle();

        // positive move: overshoot then snap, clamp both ways, truncation of a
        // negative correction, decelerate through zero and snap to approach 0
        p = '{target_speed: 13'sd300, accel_step: 8'd255, decel_step: 8'd255,
              accel_end_angle: 24'sd400, decel_start_angle: 24'sd500,
              stop_angle: 24'sd600, correction_gain: 4'd15, approach_speed: 12'd0};
        load_profile(p);
        send_item(OP_START, 24'sh800000, 21'sh100000);
        send_item(OP_TICK, 24'sd0, 21'sh0FFFFF);
        send_item(OP_TICK, 24'sd100, 21'sh100000);
        send_item(OP_TICK, 24'sd400, -21'sd17);
        send_item(OP_TICK, 24'sd450, 21'sd17);
        send_item(OP_TICK, 24'sd500, 21'sd0);
        send_item(OP_TICK, 24'sd520, 21'sd534);
        send_item(OP_TICK, 24'sd540, -21'sd534);
        send_item(OP_TICK, 24'sd560, 21'sd1);
        send_item(OP_TICK, 24'sd600, -21'sd1);   // stop: command plus zero command
        send_item(OP_TICK, 24'sd700, 21'sd5);    // done, ignored
        settle();

        // negative move: extreme thresholds, zero gain, approach speed above the
        // ramp so the snap raises the magnitude, restart in the middle
        p = '{target_speed: -13'sd4095, accel_step: 8'd255, decel_step: 8'd0,
              accel_end_angle: 24'sh800000, decel_start_angle: 24'sh800000,
              stop_angle: 24'sh7FFFFF, correction_gain: 4'd0, approach_speed: 12'd4095};
        load_profile(p);
        send_item(OP_START, 24'sd0, 21'sd0);
        send_item(OP_TICK, 24'sh800000, 21'sh0FFFFF);
        send_item(OP_TICK, -24'sd1, 21'sh100000);
        send_item(OP_TICK, 24'sd0, 21'sd3);
        send_item(OP_START, 24'sd0, 21'sd0);
        send_item(OP_TICK, 24'sd5, 21'sd0);
        send_item(OP_TICK, 24'sh7FFFFF, 21'sd0);
        send_item(OP_TICK, 24'sh7FFFFF, 21'sd0);
        send_item(OP_TICK, 24'sh7FFFFF, 21'sd0);
        send_item(OP_TICK, 24'sh7FFFFF, 21'sd0);
        settle();

        // random moves until enough transactions went in
        move_count = 0;
        while (items_sent < ITEM_TARGET) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (move_count % 6 == 0) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            // every few moves keep the old registers, so one set sees two moves
            if (move_count % 4 != 3)
                load_profile(random_profile());
            if (move_count == 8) begin
                // long hold-off on the result side while the sender keeps
                // offering, so the block fills up and drops s_ready
                tx_idle_on     = 1'b0;
                rx_hold_cycles = HOLD_CYCLES;
                run_move(40, 1'b0);
            end else begin
                run_move($urandom_range(60, 600), ($urandom_range(0, 2) == 0));
            end
            settle();
            move_count++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
